// ----- hw/rtl/psts_pkg.sv -----
// Shared types and constants for the priority sleep task scheduler.
// No dependencies; psts_pick and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package psts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TICK_BITS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int USABLE    = (MAX_TASKS < 16) ? MAX_TASKS : 16;
  localparam int PRIO_W    = 8;
  localparam int KEY_W     = PRIO_W + SLOT_W;
  localparam int PADDR_W   = 3;

  // Register index of the mode register (byte address bits above the lane).
  localparam logic [PADDR_W-3:0] REG_MODE = '0;

  typedef enum logic [2:0] {
    REQ_POLL   = 3'd0,
    REQ_CREATE = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_SUSP   = 3'd3,
    REQ_RESUME = 3'd4,
    REQ_PRIO   = 3'd5,
    REQ_SLEEP  = 3'd6,
    REQ_NONE   = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  // One task table entry as held in memory.
  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [TICK_BITS-1:0] last;
    logic [TICK_BITS-1:0] sleep;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Control from the sequencer to the candidate picker.
  typedef struct packed {
    logic              clear;
    logic              valid;
    logic              live;
    logic [SLOT_W-1:0] slot;
  } pick_ctrl_t;

  // Best candidates found by the picker.
  typedef struct packed {
    logic              found_any;
    logic [SLOT_W-1:0] slot_any;
    logic [PRIO_W-1:0] prio_any;
    logic              found_after;
    logic [SLOT_W-1:0] slot_after;
    logic [PRIO_W-1:0] prio_after;
  } pick_res_t;

  // Search key: higher priority first, ties to the lower slot.
  function automatic logic [KEY_W-1:0] order_key(input logic [PRIO_W-1:0] prio,
                                                 input logic [SLOT_W-1:0] slot);
    order_key = {~prio, slot};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/psts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/psts_pick.sv -----
// Candidate picker: checks one table entry per cycle for eligibility and keeps
// the best candidate overall and the best one after the rotation point.
// Depends on psts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psts_pick (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire psts_pkg::pick_ctrl_t           ctrl,
  input  wire psts_pkg::entry_t               entry,
  input  wire logic [psts_pkg::TICK_BITS-1:0] now,
  input  wire logic [psts_pkg::SLOT_W-1:0]    ref_slot,
  output psts_pkg::pick_res_t                 res
);

  logic [psts_pkg::KEY_W-1:0]     ref_key;
  logic [psts_pkg::KEY_W-1:0]     key_any;
  logic [psts_pkg::KEY_W-1:0]     key_after;
  logic                           found_any;
  logic                           found_after;
  logic [psts_pkg::KEY_W-1:0]     key;
  logic [psts_pkg::TICK_BITS-1:0] elapsed;
  logic                           eligible;

  assign elapsed  = now - entry.last;
  assign eligible = ctrl.valid && ctrl.live && (elapsed >= entry.sleep);
  assign key      = psts_pkg::order_key(entry.prio, ctrl.slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      found_any   <= 1'b0;
      found_after <= 1'b0;
    end else if (ctrl.clear) begin
      // The entry on the read port is the rotation point's own entry.
      found_any   <= 1'b0;
      found_after <= 1'b0;
      ref_key     <= psts_pkg::order_key(entry.prio, ref_slot);
    end else if (eligible) begin
      if (!found_any || key < key_any) begin
        found_any <= 1'b1;
        key_any   <= key;
      end
      if (key > ref_key && (!found_after || key < key_after)) begin
        found_after <= 1'b1;
        key_after   <= key;
      end
    end
  end

  always_comb begin
    res.found_any   = found_any;
    res.slot_any    = key_any[psts_pkg::SLOT_W-1:0];
    res.prio_any    = ~key_any[psts_pkg::KEY_W-1:psts_pkg::SLOT_W];
    res.found_after = found_after;
    res.slot_after  = key_after[psts_pkg::SLOT_W-1:0];
    res.prio_after  = ~key_after[psts_pkg::KEY_W-1:psts_pkg::SLOT_W];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/priority_sleep_task_scheduler.sv -----
// Top level of the priority sleep task scheduler: request sequencer, slot
// flags, mode register, output register. Depends on psts_pkg, psts_ram, psts_pick.
//
// Usage. Request words enter on the in_valid / in_stall channel, one word is
// accepted at a rising edge with in_valid high and in_stall low. Every request
// yields exactly one response word on out_valid / out_stall: status,
// result_slot and dispatched. The block handles one request at a time.
// Create, delete, suspend, resume, set priority and set sleep pass S_EXEC and
// present their response from S_DONE; the next word is taken back in S_IDLE.
// A poll reads the rotation point's entry and then scans the task table memory
// one entry per cycle over all 16 slots, then picks in S_PICK and answers from
// S_DONE; the single read port of the table memory sets the pace of the scan.
// in_stall is low only while the sequencer is idle, so a new word is taken
// while the previous response may still sit in the output register; the next
// response waits in the sequencer until the receiver has taken it. A stalled
// response holds its value.
// Reset (synchronous, active high) empties the table, clears the rotation
// point, selects priority search and drops any pending response. The table
// memory needs no clearing, since create writes every field of an entry.
// The APB port holds one register at byte address 0: round_robin_mode in bit
// 0. The user must write it only while idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module priority_sleep_task_scheduler (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Request channel.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [2:0]                     req_type,
  input  wire logic [3:0]                     task_slot,
  input  wire logic [7:0]                     task_priority,
  input  wire logic [15:0]                    now_ticks,
  input  wire logic [15:0]                    sleep_ticks,
  // Response channel.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          status,
  output logic [3:0]                          result_slot,
  output logic                                dispatched,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [psts_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_ROT  = 6'b000100,
    S_SCAN = 6'b001000,
    S_PICK = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state, state_next;

  // Registered request word.
  psts_pkg::req_t                 req;
  logic [3:0]                     slot_q;
  logic [psts_pkg::PRIO_W-1:0]    prio_q;
  logic [psts_pkg::TICK_BITS-1:0] now_q;
  logic [psts_pkg::TICK_BITS-1:0] sleep_q;

  // Slot flags live in flip-flops so reset empties the table at once.
  logic [psts_pkg::MAX_TASKS-1:0] in_use;
  logic [psts_pkg::MAX_TASKS-1:0] ready;
  logic [psts_pkg::SLOT_W-1:0]    rotation_point;
  logic                           round_robin_mode;

  // Slot whose entry is on the read port during a scan.
  logic [psts_pkg::SLOT_W-1:0]    rd_slot;

  // Pending response.
  psts_pkg::status_t              res_status;
  logic [3:0]                     res_slot;
  logic                           res_disp;

  // Table memory ports.
  logic                           ram_we;
  logic [psts_pkg::SLOT_W-1:0]    ram_waddr;
  psts_pkg::entry_t               ram_wdata;
  logic [psts_pkg::SLOT_W-1:0]    ram_raddr;
  psts_pkg::entry_t               ram_rdata;

  psts_pkg::pick_ctrl_t           pick_ctrl;
  psts_pkg::pick_res_t            pick_res;

  logic                           accept;
  logic                           out_free;
  logic                           cfg_write;
  logic                           free_found;
  logic [psts_pkg::SLOT_W-1:0]    free_slot;
  logic [psts_pkg::SLOT_W-1:0]    tgt;
  logic                           tgt_ok;
  logic                           use_after;
  logic [psts_pkg::SLOT_W-1:0]    sel_slot;
  logic [psts_pkg::PRIO_W-1:0]    sel_prio;

  psts_ram #(
    .WIDTH (psts_pkg::ENTRY_W),
    .DEPTH (psts_pkg::MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  psts_pick u_pick (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (pick_ctrl),
    .entry    (ram_rdata),
    .now      (now_q),
    .ref_slot (rotation_point),
    .res      (pick_res)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Configuration port: always ready; the byte lane bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite
                     && (paddr[psts_pkg::PADDR_W-1:2] == psts_pkg::REG_MODE);
  assign prdata    = (paddr[psts_pkg::PADDR_W-1:2] == psts_pkg::REG_MODE)
                     ? {31'd0, round_robin_mode} : 32'd0;

  // Lowest free slot for create.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = psts_pkg::USABLE - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_slot  = psts_pkg::SLOT_W'(i);
      end
    end
  end

  assign tgt    = slot_q[psts_pkg::SLOT_W-1:0];
  assign tgt_ok = (int'(slot_q) < psts_pkg::MAX_TASKS) && in_use[tgt];

  // In rotating mode the search prefers the first candidate after the rotation
  // point's entry in key order, and wraps to the overall best when there is none.
  assign use_after = round_robin_mode && pick_res.found_after;
  assign sel_slot  = use_after ? pick_res.slot_after : pick_res.slot_any;
  assign sel_prio  = use_after ? pick_res.prio_after : pick_res.prio_any;

  // Sequencer and table memory control.
  always_comb begin
    state_next      = state;
    ram_we          = 1'b0;
    ram_waddr       = tgt;
    ram_wdata       = ram_rdata;
    ram_raddr       = rd_slot;
    pick_ctrl.clear = 1'b0;
    pick_ctrl.valid = 1'b0;
    pick_ctrl.live  = in_use[rd_slot] && ready[rd_slot];
    pick_ctrl.slot  = rd_slot;

    unique case (state)
      S_IDLE: begin
        // The entry a request needs is read as the word is accepted.
        if (req_type == psts_pkg::REQ_POLL) begin
          ram_raddr = rotation_point;
        end else begin
          ram_raddr = task_slot[psts_pkg::SLOT_W-1:0];
        end
        if (accept) begin
          state_next = (req_type == psts_pkg::REQ_POLL) ? S_ROT : S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        if (req == psts_pkg::REQ_CREATE) begin
          ram_we    = free_found;
          ram_waddr = free_slot;
          ram_wdata = '{prio: prio_q, last: '0, sleep: '0};
        end else if (req == psts_pkg::REQ_PRIO) begin
          ram_we         = tgt_ok;
          ram_wdata.prio = prio_q;
        end else if (req == psts_pkg::REQ_SLEEP) begin
          ram_we          = tgt_ok;
          ram_wdata.sleep = sleep_q;
        end
      end
      S_ROT: begin
        pick_ctrl.clear = 1'b1;
        ram_raddr       = '0;
        state_next      = S_SCAN;
      end
      S_SCAN: begin
        pick_ctrl.valid = 1'b1;
        if (rd_slot == psts_pkg::SLOT_W'(psts_pkg::USABLE - 1)) begin
          state_next = S_PICK;
        end else begin
          ram_raddr = rd_slot + 1'b1;
        end
      end
      S_PICK: begin
        state_next = S_DONE;
        ram_we     = pick_res.found_any;
        ram_waddr  = sel_slot;
        ram_wdata  = '{prio: sel_prio, last: now_q, sleep: '0};
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      in_use           <= '0;
      ready            <= '0;
      rotation_point   <= '0;
      round_robin_mode <= 1'b0;
      out_valid        <= 1'b0;
      rd_slot          <= '0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        round_robin_mode <= pwdata[0];
      end

      if (state == S_ROT) begin
        rd_slot <= '0;
      end else if (state == S_SCAN) begin
        rd_slot <= ram_raddr;
      end

      if (state == S_EXEC) begin
        if (req == psts_pkg::REQ_CREATE) begin
          if (free_found) begin
            in_use[free_slot] <= 1'b1;
            ready[free_slot]  <= 1'b1;
          end
        end else if (tgt_ok) begin
          unique case (req)
            psts_pkg::REQ_DELETE: begin
              in_use[tgt] <= 1'b0;
              ready[tgt]  <= 1'b0;
            end
            psts_pkg::REQ_SUSP:   ready[tgt] <= 1'b0;
            psts_pkg::REQ_RESUME: ready[tgt] <= 1'b1;
            default: ;
          endcase
        end
      end

      if (state == S_PICK && pick_res.found_any) begin
        rotation_point <= sel_slot;
      end

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, response build and output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      req     <= psts_pkg::req_t'(req_type);
      slot_q  <= task_slot;
      prio_q  <= task_priority;
      now_q   <= now_ticks;
      sleep_q <= sleep_ticks;
    end

    if (state == S_EXEC) begin
      res_disp <= 1'b0;
      case (req) inside
        psts_pkg::REQ_CREATE: begin
          res_status <= free_found ? psts_pkg::ST_OK : psts_pkg::ST_FULL;
          res_slot   <= free_found ? 4'(free_slot) : 4'd0;
        end
        psts_pkg::REQ_DELETE, psts_pkg::REQ_SUSP, psts_pkg::REQ_RESUME,
        psts_pkg::REQ_PRIO, psts_pkg::REQ_SLEEP: begin
          res_status <= tgt_ok ? psts_pkg::ST_OK : psts_pkg::ST_NO_SLOT;
          res_slot   <= 4'd0;
        end
        default: begin
          res_status <= psts_pkg::ST_OK;
          res_slot   <= 4'd0;
        end
      endcase
    end else if (state == S_PICK) begin
      res_status <= pick_res.found_any ? psts_pkg::ST_OK : psts_pkg::ST_NONE;
      res_slot   <= pick_res.found_any ? 4'(sel_slot) : 4'd0;
      res_disp   <= pick_res.found_any;
    end

    if (state == S_DONE && out_free) begin
      status      <= res_status;
      result_slot <= res_slot;
      dispatched  <= res_disp;
    end
  end

endmodule

`default_nettype wire
